FILE: src/rde_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rde_pkg: shared definitions of the reversible deque engine
// Sizes, action and result codes, FSM states and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package rde_pkg;

  // Ring store geometry (DEPTH in 2..64)
  localparam int unsigned DEPTH  = 64;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    ACT_PUSH    = 2'd0,
    ACT_REVERSE = 2'd1,
    ACT_DELETE  = 2'd2,
    ACT_FINISH  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KIND_ELEMENT = 2'd0,
    KIND_EMPTY   = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef enum logic {
    ST_IDLE,
    ST_STREAM
  } state_e;

  // Controller -> datapath
  typedef struct packed {
    logic  push;
    logic  reverse;
    logic  del;
    logic  set_err;
    logic  clear;
    logic  load_single;
    kind_e single_kind;
    logic  start;
    logic  rd_issue;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic empty;
    logic full;
    logic error;
    logic remain_one;
    logic rd_busy;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

FILE: src/rde_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rde_if: valid/ready channels of the reversible deque engine
// rde_req_if carries action beats in, rde_rsp_if carries result beats out.
// ----------------------------------------------------------------------------
interface rde_req_if;
  logic                                valid;
  logic                                ready;
  rde_pkg::action_e                    action;
  logic signed [rde_pkg::DATA_W-1:0]   value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface rde_rsp_if;
  logic                                valid;
  logic                                ready;
  rde_pkg::kind_e                      kind;
  logic signed [rde_pkg::DATA_W-1:0]   element;
  logic                                last;

  modport source (output valid, output kind, output element, output last, input ready);
  modport sink   (input valid, input kind, input element, input last, output ready);
endinterface
`default_nettype wire

FILE: src/reversible_deque_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// reversible_deque_engine: reversible double-ended list in a ring store
// Push at back, reverse, delete front and finish; finish streams the list.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries action beats (push, reverse, delete front, finish) with a
//   32-bit signed value; rsp_o carries result beats (kind, element, last).
//   Push, reverse and delete give no result.
//   A finish on an empty or errored list gives one beat in the next cycle.
//   Otherwise finish streams count elements in logical order: the first beat
//   passes the stream read pointer, the read stage and the output register,
//   then one beat per cycle while the receiver is ready, paced by the single
//   read port of the store. req_i.ready is low while the stream is read out.
//   A stalled receiver holds rsp_o steady; the read stage and the output
//   register keep the stream and nothing is lost or repeated.
//   Reset clears pointers, count, direction and error flags; store contents
//   are not cleared and are only read after being written.
//   Every finish returns the list to its reset state.
// ----------------------------------------------------------------------------
module reversible_deque_engine (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  rde_req_if.sink    req_i,
  rde_rsp_if.source  rsp_o
);

  rde_pkg::cmd_t    cmd;
  rde_pkg::status_t status;
  logic             in_ready;

  assign req_i.ready = in_ready;

  rde_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .action_i   (req_i.action),
    .status_i   (status),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  rde_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .value_i     (req_i.value),
    .out_ready_i (rsp_o.ready),
    .status_o    (status),
    .out_valid_o (rsp_o.valid),
    .kind_o      (rsp_o.kind),
    .element_o   (rsp_o.element),
    .last_o      (rsp_o.last)
  );

endmodule
`default_nettype wire

FILE: src/rde_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rde_ctrl: controller of the reversible deque engine
// Decodes accepted actions into datapath commands and sequences the
// finish stream, one store read per cycle unless a stalled output holds the read stage.
// ----------------------------------------------------------------------------
module rde_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire rde_pkg::action_e action_i,
  input  wire rde_pkg::status_t status_i,
  output logic                  in_ready_o,
  output rde_pkg::cmd_t         cmd_o
);

  rde_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rde_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      rde_pkg::ST_IDLE: begin
        // read pipe empty and output slot free for a possible single result
        in_ready_o = !status_i.rd_busy && status_i.out_free;
        if (in_valid_i && in_ready_o) begin
          case (action_i)
            rde_pkg::ACT_PUSH: begin
              cmd_o.push = !status_i.error && !status_i.full;
            end
            rde_pkg::ACT_REVERSE: begin
              cmd_o.reverse = !status_i.error;
            end
            rde_pkg::ACT_DELETE: begin
              if (!status_i.error) begin
                cmd_o.set_err = status_i.empty;
                cmd_o.del     = !status_i.empty;
              end
            end
            rde_pkg::ACT_FINISH: begin
              cmd_o.clear = 1'b1;
              if (status_i.error) begin
                cmd_o.load_single = 1'b1;
                cmd_o.single_kind = rde_pkg::KIND_ERROR;
              end else if (status_i.empty) begin
                cmd_o.load_single = 1'b1;
                cmd_o.single_kind = rde_pkg::KIND_EMPTY;
              end else begin
                cmd_o.start = 1'b1;
                state_d     = rde_pkg::ST_STREAM;
              end
            end
            default: begin
              cmd_o = '0;
            end
          endcase
        end
      end
      rde_pkg::ST_STREAM: begin
        // issue a read whenever the read stage will be free next cycle
        if (!status_i.rd_busy || status_i.out_free) begin
          cmd_o.rd_issue = 1'b1;
          if (status_i.remain_one) begin
            state_d = rde_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = rde_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: src/rde_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rde_datapath: ring store and pointers of the reversible deque engine
// Holds the store memory, head/tail/count, direction and error flags, the
// stream read pointer, the registered read stage and the output register.
// ----------------------------------------------------------------------------
module rde_datapath (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire rde_pkg::cmd_t                     cmd_i,
  input  wire logic signed [rde_pkg::DATA_W-1:0] value_i,
  input  wire logic                              out_ready_i,
  output rde_pkg::status_t                       status_o,
  output logic                                   out_valid_o,
  output rde_pkg::kind_e                         kind_o,
  output logic signed [rde_pkg::DATA_W-1:0]      element_o,
  output logic                                   last_o
);

  localparam int unsigned IW = rde_pkg::IDX_W;
  localparam int unsigned CW = rde_pkg::CNT_W;

  function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] i);
    return (i == IW'(rde_pkg::DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IW-1:0] ring_dec(input logic [IW-1:0] i);
    return (i == '0) ? IW'(rde_pkg::DEPTH - 1) : i - 1'b1;
  endfunction

  logic signed [rde_pkg::DATA_W-1:0] mem [rde_pkg::DEPTH];

  logic [IW-1:0] head_q, head_d, tail_q, tail_d, pos_q, pos_d;
  logic [CW-1:0] count_q, count_d, remain_q, remain_d;
  logic          rev_q, rev_d, err_q, err_d, dir_q, dir_d;
  logic          rd_v_q, rd_v_d, rd_last_q, rd_last_d;
  logic signed [rde_pkg::DATA_W-1:0] rdata_q;
  logic          out_v_q, out_v_d;
  rde_pkg::kind_e out_kind_q;
  logic signed [rde_pkg::DATA_W-1:0] out_elem_q;
  logic          out_last_q;
  logic          advance;
  logic [IW-1:0] wr_addr;

  assign advance = !out_v_q || out_ready_i;
  assign wr_addr = rev_q ? ring_dec(head_q) : tail_q;

  // List pointers and flags
  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    rev_d   = rev_q;
    err_d   = err_q;
    if (cmd_i.clear) begin
      head_d  = '0;
      tail_d  = '0;
      count_d = '0;
      rev_d   = 1'b0;
      err_d   = 1'b0;
    end else if (cmd_i.push) begin
      if (rev_q) begin
        head_d = ring_dec(head_q);
      end else begin
        tail_d = ring_inc(tail_q);
      end
      count_d = count_q + 1'b1;
    end else if (cmd_i.reverse) begin
      rev_d = !rev_q;
    end else if (cmd_i.del) begin
      if (rev_q) begin
        tail_d = ring_dec(tail_q);
      end else begin
        head_d = ring_inc(head_q);
      end
      count_d = count_q - 1'b1;
    end else if (cmd_i.set_err) begin
      err_d = 1'b1;
    end
  end

  // Stream read pointer and read stage
  always_comb begin
    pos_d     = pos_q;
    remain_d  = remain_q;
    dir_d     = dir_q;
    rd_last_d = rd_last_q;
    if (cmd_i.start) begin
      pos_d    = rev_q ? ring_dec(tail_q) : head_q;
      remain_d = count_q;
      dir_d    = rev_q;
    end else if (cmd_i.rd_issue) begin
      pos_d     = dir_q ? ring_dec(pos_q) : ring_inc(pos_q);
      remain_d  = remain_q - 1'b1;
      rd_last_d = (remain_q == CW'(1));
    end
    if (cmd_i.rd_issue) begin
      rd_v_d = 1'b1;
    end else if (advance) begin
      rd_v_d = 1'b0;
    end else begin
      rd_v_d = rd_v_q;
    end
    out_v_d = advance ? (rd_v_q || cmd_i.load_single) : out_v_q;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= '0;
      rev_q     <= 1'b0;
      err_q     <= 1'b0;
      pos_q     <= '0;
      remain_q  <= '0;
      dir_q     <= 1'b0;
      rd_v_q    <= 1'b0;
      rd_last_q <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      rev_q     <= rev_d;
      err_q     <= err_d;
      pos_q     <= pos_d;
      remain_q  <= remain_d;
      dir_q     <= dir_d;
      rd_v_q    <= rd_v_d;
      rd_last_q <= rd_last_d;
      out_v_q   <= out_v_d;
    end
  end

  // Store memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[wr_addr] <= value_i;
    end
    if (cmd_i.rd_issue) begin
      rdata_q <= mem[pos_q];
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (rd_v_q) begin
        out_kind_q <= rde_pkg::KIND_ELEMENT;
        out_elem_q <= rdata_q;
        out_last_q <= rd_last_q;
      end else if (cmd_i.load_single) begin
        out_kind_q <= cmd_i.single_kind;
        out_elem_q <= '0;
        out_last_q <= 1'b1;
      end
    end
  end

  assign status_o.empty      = (count_q == '0);
  assign status_o.full       = (count_q == CW'(rde_pkg::DEPTH));
  assign status_o.error      = err_q;
  assign status_o.remain_one = (remain_q == CW'(1));
  assign status_o.rd_busy    = rd_v_q;
  assign status_o.out_free   = advance;

  assign out_valid_o = out_v_q;
  assign kind_o      = out_kind_q;
  assign element_o   = out_elem_q;
  assign last_o      = out_last_q;

endmodule
`default_nettype wire

FILE: src/rde_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rde_checker: port-level checks of the reversible deque engine
// Watches both channels of the top level; bound in below.
// ----------------------------------------------------------------------------
module rde_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_valid_i,
  input wire logic                              in_ready_i,
  input wire rde_pkg::action_e                  in_action_i,
  input wire logic                              out_valid_i,
  input wire logic                              out_ready_i,
  input wire rde_pkg::kind_e                    out_kind_i,
  input wire logic signed [rde_pkg::DATA_W-1:0] out_element_i,
  input wire logic                              out_last_i
);

  // A stalled result beat stays valid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("rsp valid dropped while stalled");

  // A stalled result beat holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_kind_i) && $stable(out_element_i) && $stable(out_last_i))
    else $error("rsp payload changed while stalled");

  // While a stream is mid-way, no new action is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !out_last_i |-> !in_ready_i)
    else $error("action accepted in the middle of a finish stream");

  // Non-finish actions never produce a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_action_i != rde_pkg::ACT_FINISH) && !out_valid_i
      |=> !out_valid_i)
    else $error("result produced by a non-finish action");

endmodule

bind reversible_deque_engine rde_checker u_rde_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (req_i.valid),
  .in_ready_i    (req_i.ready),
  .in_action_i   (req_i.action),
  .out_valid_i   (rsp_o.valid),
  .out_ready_i   (rsp_o.ready),
  .out_kind_i    (rsp_o.kind),
  .out_element_i (rsp_o.element),
  .out_last_i    (rsp_o.last)
);
`default_nettype wire
